### rtl/core/crc16_frame_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef CRC16_FRAME_DEFRAMER_ASSERT_SVH
`define CRC16_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define DFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define DFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dfr_pkg.sv
// Types, constants and the CRC byte update for the frame deframer.
package dfr_pkg;

	localparam int unsigned MaxFrameBytes = 255;
	localparam int unsigned MinFrameBytes = 14;
	localparam int unsigned FifoDepth     = 4;
	localparam int unsigned FifoPtrW      = $clog2(FifoDepth);
	localparam int unsigned FifoCntW      = $clog2(FifoDepth + 1);

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	localparam logic [1:0] StOk     = 2'd0;
	localparam logic [1:0] StHeader = 2'd1;
	localparam logic [1:0] StCrc    = 2'd2;
	localparam logic [1:0] StLength = 2'd3;

	localparam logic KindPayload = 1'b0;
	localparam logic KindVerdict = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload;
		logic [1:0]  status;
		logic [7:0]  ftype;
		logic [7:0]  cmd;
		logic [15:0] code;
		logic [15:0] length;
		logic        last;
	} dfr_item_t;

	// Up to two results per byte, payload first, verdict second.
	typedef struct packed {
		logic      pay_valid;
		dfr_item_t pay_item;
		logic      vrd_valid;
		dfr_item_t vrd_item;
	} dfr_push_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/core/crc16_frame_deframer.sv
// Top level of the CRC-16 checked frame deframer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_stall  | rx_byte, end_of_frame
//  output   | out_valid / out_stall| item_kind, payload_byte, status, frame_type,
//           |                      | command, code_word, payload_length, last
//  config   | APB write/read       | header_byte_0..3 at 0x0, 0x4, 0x8, 0xC
//
// One byte per cycle sustained while the result queue has room for two results. A
// byte passes from the input register into the result queue, and its results are
// offered on the output once they are written into the queue.
// The final byte of a frame can make two results, so the output side may fall behind
// the input at frame ends; the input stalls only while the queue cannot take two more.
// Reset clears frame state, config registers, input valid flag and queue pointers;
// the byte register and queue storage keep their contents.
module crc16_frame_deframer
	import dfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_frame,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [7:0]  payload_byte,
	output logic [1:0]  status,
	output logic [7:0]  frame_type,
	output logic [7:0]  command,
	output logic [15:0] code_word,
	output logic [15:0] payload_length,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "crc16_frame_deframer_assert.svh"

	// header compare bytes, one per word
	logic [3:0][7:0] hdr_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	logic                go;
	logic                room;
	logic                pop;
	dfr_push_t           push;
	dfr_item_t           head;
	logic [FifoCntW-1:0] level;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign prdata = {24'h000000, hdr_q[paddr[3:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			hdr_q[paddr[3:2]] <= pwdata[7:0];
		end
	end

	// ---- input register ----
	// The byte in s1 moves on when the queue has room for two results.
	assign room     = level <= FifoCntW'(FifoDepth - 2);
	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			eof_s1  <= end_of_frame;
		end
	end

	// ---- parse and check ----
	dfr_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.rx_byte (byte_s1),
		.eof     (eof_s1),
		.hdr     (hdr_q),
		.push    (push)
	);

	// ---- result queue ----
	assign out_valid = level != '0;
	assign pop       = out_valid && !out_stall;

	dfr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	assign item_kind      = head.kind;
	assign payload_byte   = head.payload;
	assign status         = head.status;
	assign frame_type     = head.ftype;
	assign command        = head.cmd;
	assign code_word      = head.code;
	assign payload_length = head.length;
	assign last           = head.last;

	// ---- checks ----
	`DFR_ASSERT_NOW(a_stall_only_full, clk, arst_n, in_stall, level > FifoCntW'(FifoDepth - 2), "input stalled while queue has room")
	`DFR_ASSERT_NOW(a_no_overflow, clk, arst_n, 1'b1, level <= FifoCntW'(FifoDepth), "result queue overflow")
	`DFR_ASSERT_NEXT(a_eof_gives_result, clk, arst_n, go && eof_s1, level != '0, "frame end left no verdict queued")
	`DFR_ASSERT_NOW(a_payload_clean, clk, arst_n, out_valid && item_kind == KindPayload, status == StOk && !last, "payload transfer carries verdict bits")

endmodule

### rtl/core/dfr_parse.sv
// Frame parser: delay line, CRC accumulator, field capture and verdict.
module dfr_parse
	import dfr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [7:0]      rx_byte,
	input  logic            eof,
	input  logic [3:0][7:0] hdr,
	output dfr_push_t       push
);

	logic [3:0][7:0] dl_q, dl_n;
	logic [15:0]     crc_q, crc_n;
	logic [7:0]      cnt_q, cnt_n;
	logic            hgood_q, hgood_n;
	logic [7:0]      type_q, type_n;
	logic [7:0]      cmd_q, cmd_n;
	logic [15:0]     code_q, code_n;
	logic [15:0]     len_q, len_n;

	always_comb begin
		logic [7:0]  ob;
		logic [7:0]  idx;
		logic [15:0] rx_crc;
		logic [1:0]  st;
		logic        clr;

		dl_n    = dl_q;
		crc_n   = crc_q;
		cnt_n   = cnt_q;
		hgood_n = hgood_q;
		type_n  = type_q;
		cmd_n   = cmd_q;
		code_n  = code_q;
		len_n   = len_q;
		push    = '0;
		ob      = dl_q[3];
		idx     = cnt_q - 8'd4;
		rx_crc  = {dl_q[1], dl_q[2]};
		st      = StOk;
		clr     = 1'b0;

		if (go) begin
			if (cnt_q >= 8'(MaxFrameBytes)) begin
				// saturated frame: drop bytes until the end marker
				if (eof) begin
					push.vrd_valid       = 1'b1;
					push.vrd_item.kind   = KindVerdict;
					push.vrd_item.status = StLength;
					push.vrd_item.last   = 1'b1;
					clr                  = 1'b1;
				end
			end else begin
				if (cnt_q >= 8'd4) begin
					crc_n = crc16_byte(crc_q, ob);
					if (idx < 8'd4) begin
						if (ob != hdr[idx[1:0]]) begin
							hgood_n = 1'b0;
						end
					end else if (idx == 8'd4) begin
						type_n = ob;
					end else if (idx == 8'd5) begin
						cmd_n = ob;
					end else if (idx == 8'd6) begin
						code_n = {ob, 8'h00};
					end else if (idx == 8'd7) begin
						code_n = {code_q[15:8], ob};
					end else if (idx == 8'd8) begin
						len_n = {ob, 8'h00};
					end else if (idx == 8'd9) begin
						len_n = {len_q[15:8], ob};
					end else if ({8'h00, idx - 8'd10} < len_q) begin
						push.pay_valid        = 1'b1;
						push.pay_item.kind    = KindPayload;
						push.pay_item.payload = ob;
					end
				end
				dl_n  = {dl_q[2:0], rx_byte};
				cnt_n = cnt_q + 8'd1;
				if (eof) begin
					if (cnt_n < 8'(MinFrameBytes)) begin
						st = StLength;
					end else if (!hgood_n) begin
						st = StHeader;
					end else if (rx_crc != crc_n) begin
						st = StCrc;
					end else if (len_n > {8'h00, cnt_n - 8'(MinFrameBytes)}) begin
						st = StLength;
					end else begin
						st = StOk;
					end
					push.vrd_valid       = 1'b1;
					push.vrd_item.kind   = KindVerdict;
					push.vrd_item.status = st;
					push.vrd_item.last   = 1'b1;
					if (st == StOk) begin
						push.vrd_item.ftype  = type_n;
						push.vrd_item.cmd    = cmd_n;
						push.vrd_item.code   = code_n;
						push.vrd_item.length = len_n;
					end
					clr = 1'b1;
				end
			end
		end

		if (clr) begin
			dl_n    = '0;
			crc_n   = CrcInit;
			cnt_n   = '0;
			hgood_n = 1'b1;
			type_n  = '0;
			cmd_n   = '0;
			code_n  = '0;
			len_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_q    <= '0;
			crc_q   <= CrcInit;
			cnt_q   <= '0;
			hgood_q <= 1'b1;
			type_q  <= '0;
			cmd_q   <= '0;
			code_q  <= '0;
			len_q   <= '0;
		end else begin
			dl_q    <= dl_n;
			crc_q   <= crc_n;
			cnt_q   <= cnt_n;
			hgood_q <= hgood_n;
			type_q  <= type_n;
			cmd_q   <= cmd_n;
			code_q  <= code_n;
			len_q   <= len_n;
		end
	end

endmodule

### rtl/core/dfr_fifo.sv
// Result queue: takes up to two items per cycle, hands out one per transfer.
module dfr_fifo
	import dfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dfr_push_t           push,
	input  logic                pop,
	output dfr_item_t           head,
	output logic [FifoCntW-1:0] level
);

	dfr_item_t             mem_q [FifoDepth];
	logic [FifoPtrW-1:0]   wr_q, rd_q;
	logic [FifoCntW-1:0]   cnt_q;
	logic [FifoCntW-1:0]   n_push;

	assign n_push = FifoCntW'(push.pay_valid) + FifoCntW'(push.vrd_valid);
	assign head   = mem_q[rd_q];
	assign level  = cnt_q;

	always_ff @(posedge clk) begin
		if (push.pay_valid) begin
			mem_q[wr_q] <= push.pay_item;
			if (push.vrd_valid) begin
				mem_q[wr_q + FifoPtrW'(1)] <= push.vrd_item;
			end
		end else if (push.vrd_valid) begin
			mem_q[wr_q] <= push.vrd_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FifoPtrW'(n_push);
			rd_q  <= rd_q + FifoPtrW'(pop);
			cnt_q <= cnt_q + n_push - FifoCntW'(pop);
		end
	end

endmodule
